[hw/rtl/lese_pkg.sv]
// Shared types, constants and helper functions of the segment envelope.
// Depends on nothing; every other file of the block but the table memory imports it.
`timescale 1ns / 1ps

package lese_pkg;

  // Output queue geometry
  localparam int OutDepth = 4;
  localparam int OutPtrW  = $clog2(OutDepth);
  localparam int OutCntW  = $clog2(OutDepth + 1);

  // Fixed-point constants: rates unsigned Q1.30, levels signed Q2.22
  localparam logic [30:0]        RateOne  = 31'h4000_0000;
  localparam logic signed [31:0] RateOneS = 32'sh4000_0000;
  localparam logic signed [31:0] DestMax  = 32'sd8388607;
  localparam logic signed [31:0] DestMin  = -32'sd8388608;

  typedef enum logic [2:0] {
    OpTick      = 3'd0,
    OpKeyDown   = 3'd1,
    OpKeyUp     = 3'd2,
    OpWriteRate = 3'd3,
    OpWriteDest = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CfgPhases     = 3'd0,
    CfgSuccessors = 3'd1,
    CfgStart      = 3'd2,
    CfgStop       = 3'd3,
    CfgThreshold  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhLinear = 2'd1,
    PhExp    = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0]  phases;
    logic [7:0]  successors;
    logic [1:0]  start_seg;
    logic [1:0]  stop_seg;
    logic [30:0] threshold;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    phases:     8'd36,
    successors: 8'd0,
    start_seg:  2'd1,
    stop_seg:   2'd2,
    threshold:  31'd1
  };

  // Per-voice state word held in the state memory
  typedef struct packed {
    phase_e             phase;
    logic [1:0]         seg;
    logic [1:0]         succ;
    logic [30:0]        x;
    logic [30:0]        y;
    logic signed [23:0] start;
    logic signed [23:0] cur;
  } voice_state_t;

  typedef struct packed {
    logic [4:0]         voice;
    logic signed [23:0] level;
    logic [1:0]         phase;
  } result_t;

  // Phase of a segment; the unused code reads as idle
  function automatic phase_e phase_of(input logic [7:0] phases, input logic [1:0] s);
    logic [1:0] p;
    p = phases[{s, 1'b0} +: 2];
    unique case (p)
      2'd1:    return PhLinear;
      2'd2:    return PhExp;
      default: return PhIdle;
    endcase
  endfunction

  function automatic logic [1:0] successor_of(input logic [7:0] succs, input logic [1:0] s);
    return succs[{s, 1'b0} +: 2];
  endfunction

  // Clamp a written rate to 0..1.0
  function automatic logic [30:0] sat_rate(input logic signed [31:0] v);
    if (v < 32'sd0) begin
      return '0;
    end else if (v > RateOneS) begin
      return RateOne;
    end
    return v[30:0];
  endfunction

  // Clamp a written destination to the 24-bit level range
  function automatic logic signed [23:0] sat_dest(input logic signed [31:0] v);
    if (v < DestMin) begin
      return DestMin[23:0];
    end else if (v > DestMax) begin
      return DestMax[23:0];
    end
    return v[23:0];
  endfunction

endpackage

[hw/rtl/lese_state_ram.sv]
// Per-voice state memory: one write port, one registered read port.
// Valid bits make unwritten voices read as zero; the latest write is forwarded.
`timescale 1ns / 1ps

module lese_state_ram #(
  parameter int VOICES = 32,
  parameter int AW     = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [AW-1:0]          rd_addr_i,
  input  logic                   wr_en_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  lese_pkg::voice_state_t wr_data_i,
  output lese_pkg::voice_state_t rd_data_o
);
  import lese_pkg::*;

  voice_state_t mem_q [VOICES];
  logic [VOICES-1:0] vld_q;

  voice_state_t rd_q;
  logic         rd_vld_q;
  logic [AW-1:0] rd_addr_q;

  logic          fwd_v_q;
  logic [AW-1:0] fwd_addr_q;
  voice_state_t  fwd_q;

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q      <= mem_q[rd_addr_i];
      rd_vld_q  <= vld_q[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  // Mark written entries and hold the latest write for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      fwd_v_q <= 1'b0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
      fwd_v_q          <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      fwd_addr_q <= wr_addr_i;
      fwd_q      <= wr_data_i;
    end
  end

  // Prefer the latest write to the same voice over the array word
  always_comb begin
    if (fwd_v_q && fwd_addr_q == rd_addr_q) begin
      rd_data_o = fwd_q;
    end else if (rd_vld_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

[hw/rtl/lese_table_ram.sv]
// Rate and destination memories, one row of segment lanes per voice.
// Lane writes, whole-row registered reads. Depends on nothing outside this file.
`timescale 1ns / 1ps

module lese_table_ram #(
  parameter int VOICES   = 32,
  parameter int SEGMENTS = 4,
  parameter int AW       = 5,
  parameter int SW       = 2
) (
  input  logic                             clk_i,
  input  logic                             wr_rate_i,
  input  logic                             wr_dest_i,
  input  logic [AW-1:0]                    wr_addr_i,
  input  logic [SW-1:0]                    wr_lane_i,
  input  logic [30:0]                      wr_rate_data_i,
  input  logic signed [23:0]               wr_dest_data_i,
  input  logic                             rd_en_i,
  input  logic [AW-1:0]                    rd_addr_i,
  output logic [SEGMENTS-1:0][30:0]        rate_row_o,
  output logic [SEGMENTS-1:0][23:0]        dest_row_o
);

  logic [SEGMENTS-1:0][30:0] rate_mem_q [VOICES];
  logic [SEGMENTS-1:0][23:0] dest_mem_q [VOICES];

  // Write one lane, read a whole row
  always_ff @(posedge clk_i) begin
    if (wr_rate_i) begin
      rate_mem_q[wr_addr_i][wr_lane_i] <= wr_rate_data_i;
    end
    if (wr_dest_i) begin
      dest_mem_q[wr_addr_i][wr_lane_i] <= wr_dest_data_i;
    end
    if (rd_en_i) begin
      rate_row_o <= rate_mem_q[rd_addr_i];
      dest_row_o <= dest_mem_q[rd_addr_i];
    end
  end

endmodule

[hw/rtl/lese_update.sv]
// Two-stage state update: decide and select segment values, then multiply
// and accumulate. Depends on lese_pkg.
`timescale 1ns / 1ps

module lese_update #(
  parameter int SEGMENTS = 4,
  parameter int SW       = 2
) (
  input  logic                      clk_i,
  input  logic                      ld_i,
  input  logic [2:0]                op_i,
  input  lese_pkg::voice_state_t    state_i,
  input  logic [SEGMENTS-1:0][30:0] rate_row_i,
  input  logic [SEGMENTS-1:0][23:0] dest_row_i,
  input  lese_pkg::cfg_t            cfg_i,
  output lese_pkg::voice_state_t    state_o
);
  import lese_pkg::*;

  localparam logic [3:0] SegCount = 4'(SEGMENTS);

  function automatic logic [30:0] rate_lane(input logic [SEGMENTS-1:0][30:0] row,
                                            input logic [1:0] seg);
    logic [3:0] w;
    w = {2'b00, seg};
    if (w < SegCount) begin
      return row[w[SW-1:0]];
    end
    return '0;
  endfunction

  function automatic logic [23:0] dest_lane(input logic [SEGMENTS-1:0][23:0] row,
                                            input logic [1:0] seg);
    logic [3:0] w;
    w = {2'b00, seg};
    if (w < SegCount) begin
      return row[w[SW-1:0]];
    end
    return '0;
  endfunction

  voice_state_t       nx_d, nx_q;
  logic               mul_lvl_d, mul_lvl_q;
  logic               mul_y_d, mul_y_q;
  logic signed [24:0] diff_d, diff_q;
  logic [30:0]        fac_d, fac_q;
  logic [30:0]        y_q;
  logic [30:0]        omr_d, omr_q;

  logic [30:0]        rate_cur;
  logic signed [23:0] dest_cur;
  logic [30:0]        rate_tgt;
  logic               enter;
  logic [1:0]         tgt;

  // Stage one: pick segment values, decide the step, settle non-product fields
  always_comb begin
    rate_cur  = rate_lane(rate_row_i, state_i.seg);
    dest_cur  = $signed(dest_lane(dest_row_i, state_i.seg));
    diff_d    = {dest_cur[23], dest_cur} - {state_i.start[23], state_i.start};
    omr_d     = RateOne - rate_cur;
    nx_d      = state_i;
    mul_lvl_d = 1'b0;
    mul_y_d   = 1'b0;
    fac_d     = state_i.x;
    enter     = 1'b0;
    tgt       = state_i.succ;

    unique case (op_i)
      OpTick: begin
        case (state_i.phase)
          PhLinear: begin
            if (state_i.x < RateOne) begin
              mul_lvl_d = 1'b1;
              nx_d.x    = state_i.x + rate_cur;
            end else begin
              nx_d.cur = dest_cur;
              enter    = 1'b1;
            end
          end
          PhExp: begin
            if (state_i.y > cfg_i.threshold) begin
              mul_lvl_d = 1'b1;
              mul_y_d   = 1'b1;
              fac_d     = RateOne - state_i.y;
            end else begin
              nx_d.cur = dest_cur;
              enter    = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OpKeyDown: begin
        enter = 1'b1;
        tgt   = cfg_i.start_seg;
      end
      OpKeyUp: begin
        enter = 1'b1;
        tgt   = cfg_i.stop_seg;
      end
      default: ;
    endcase

    // Enter the target segment from the level just reached
    rate_tgt = rate_lane(rate_row_i, tgt);
    if (enter) begin
      nx_d.x     = rate_tgt;
      nx_d.y     = RateOne - rate_tgt;
      nx_d.start = nx_d.cur;
      nx_d.phase = phase_of(cfg_i.phases, tgt);
      nx_d.seg   = tgt;
      nx_d.succ  = successor_of(cfg_i.successors, tgt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      nx_q      <= nx_d;
      mul_lvl_q <= mul_lvl_d;
      mul_y_q   <= mul_y_d;
      diff_q    <= diff_d;
      fac_q     <= fac_d;
      y_q       <= state_i.y;
      omr_q     <= omr_d;
    end
  end

  // Stage two: scale the span and shrink the remainder, truncating low bits
  logic signed [56:0] prod_lvl;
  logic [61:0]        prod_y;

  assign prod_lvl = diff_q * $signed({1'b0, fac_q});
  assign prod_y   = y_q * omr_q;

  always_comb begin
    state_o = nx_q;
    if (mul_lvl_q) begin
      state_o.cur = nx_q.start + $signed(prod_lvl[53:30]);
    end
    if (mul_y_q) begin
      state_o.y = prod_y[60:30];
    end
  end

endmodule

[hw/rtl/lese_out_fifo.sv]
// Small result queue that parts the update pipeline from the output port.
// Depends on lese_pkg for the result word and the queue depth.
`timescale 1ns / 1ps

module lese_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  lese_pkg::result_t              push_data_i,
  output logic                           pop_valid_o,
  input  logic                           pop_ready_i,
  output lese_pkg::result_t              pop_data_o,
  output logic [lese_pkg::OutCntW-1:0]   fill_o
);
  import lese_pkg::*;

  result_t              slot_q [OutDepth];
  logic [OutPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OutCntW-1:0]   cnt_q;
  logic                 pop;

  assign pop         = pop_valid_o & pop_ready_i;
  assign pop_valid_o = cnt_q != '0;
  assign pop_data_o  = slot_q[rd_ptr_q];
  assign fill_o      = cnt_q;

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OutPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OutPtrW'(1);
      end
      cnt_q <= cnt_q + OutCntW'(push_i) - OutCntW'(pop);
    end
  end

endmodule

[hw/rtl/linear_exponential_segment_envelope.sv]
// Segment envelope for many voices, state kept in memories with registered reads.
// Each input word is read, decided and multiplied before it enters the output queue.
// Throughput: one word per cycle while the output queue has room; a word for the
// same voice as the word just ahead of it waits for that word's write-back (state memory port).
// Reset: configuration to defaults, all voices read as idle at level zero at
// once through per-voice valid bits; rate and destination tables are not cleared.
`timescale 1ns / 1ps

module linear_exponential_segment_envelope #(
  parameter int VOICES   = 32,
  parameter int SEGMENTS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic [4:0]         voice_i,
  input  logic [1:0]         segment_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [4:0]         voice_out_o,
  output logic signed [23:0] level_o,
  output logic [1:0]         phase_out_o
);
  import lese_pkg::*;

  localparam int AW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SW   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int VexW = (AW > 5) ? AW : 5;
  localparam logic [8:0] VoiceCount = 9'(VOICES);
  localparam logic [3:0] SegCount   = 4'(SEGMENTS);

  // Configuration registers
  cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPhases:     cfg_d.phases     = cfg_data_i[7:0];
        CfgSuccessors: cfg_d.successors = cfg_data_i[7:0];
        CfgStart:      cfg_d.start_seg  = cfg_data_i[1:0];
        CfgStop:       cfg_d.stop_seg   = cfg_data_i[1:0];
        CfgThreshold:  cfg_d.threshold  = cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Decode the incoming word
  logic            accept;
  logic [VexW-1:0] voice_ext;
  logic [AW-1:0]   in_addr;
  logic            in_in_range;
  logic [3:0]      seg_wide;
  logic            seg_ok;
  logic [SW-1:0]   seg_lane;

  assign accept      = in_valid_i & in_ready_o;
  assign voice_ext   = VexW'(voice_i);
  assign in_addr     = voice_ext[AW-1:0];
  assign in_in_range = {4'd0, voice_i} < VoiceCount;
  assign seg_wide    = {2'b00, segment_i};
  assign seg_ok      = seg_wide < SegCount;
  assign seg_lane    = seg_wide[SW-1:0];

  // Pipeline control
  logic          s1_valid_q, s2_valid_q;
  logic [2:0]    s1_op_q;
  logic [4:0]    s1_voice_q, s2_voice_q;
  logic [AW-1:0] s1_addr_q, s2_addr_q;
  logic          s1_in_range_q, s2_in_range_q;
  logic          stall;
  logic          s1_adv;
  logic [OutCntW-1:0] fill;
  logic [OutCntW-1:0] in_flight;

  // Hold a word whose voice is still being written back
  assign stall  = s1_valid_q & s2_valid_q & s2_in_range_q & (s1_addr_q == s2_addr_q);
  assign s1_adv = s1_valid_q & ~stall;

  assign in_flight  = fill + OutCntW'(s1_valid_q) + OutCntW'(s2_valid_q);
  assign in_ready_o = ~stall & (in_flight < OutCntW'(OutDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept | (s1_valid_q & stall);
      s2_valid_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q       <= operation_i;
      s1_voice_q    <= voice_i;
      s1_addr_q     <= in_addr;
      s1_in_range_q <= in_in_range;
    end
    if (s1_adv) begin
      s2_voice_q    <= s1_voice_q;
      s2_addr_q     <= s1_addr_q;
      s2_in_range_q <= s1_in_range_q;
    end
  end

  // Tables: write a lane on an accepted rate or destination write, read the voice's rows for the update
  logic                      wr_rate, wr_dest;
  logic [SEGMENTS-1:0][30:0] rate_row;
  logic [SEGMENTS-1:0][23:0] dest_row;

  assign wr_rate = accept & in_in_range & seg_ok & (operation_i == OpWriteRate);
  assign wr_dest = accept & in_in_range & seg_ok & (operation_i == OpWriteDest);

  lese_table_ram #(
    .VOICES  (VOICES),
    .SEGMENTS(SEGMENTS),
    .AW      (AW),
    .SW      (SW)
  ) u_table (
    .clk_i         (clk_i),
    .wr_rate_i     (wr_rate),
    .wr_dest_i     (wr_dest),
    .wr_addr_i     (in_addr),
    .wr_lane_i     (seg_lane),
    .wr_rate_data_i(sat_rate(value_i)),
    .wr_dest_data_i(sat_dest(value_i)),
    .rd_en_i       (accept),
    .rd_addr_i     (in_addr),
    .rate_row_o    (rate_row),
    .dest_row_o    (dest_row)
  );

  // Voice state: read on accept, write back from the second stage
  voice_state_t cur_state;
  voice_state_t next_state;
  logic         wb_en;

  assign wb_en = s2_valid_q & s2_in_range_q;

  lese_state_ram #(
    .VOICES(VOICES),
    .AW    (AW)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(in_addr),
    .wr_en_i  (wb_en),
    .wr_addr_i(s2_addr_q),
    .wr_data_i(next_state),
    .rd_data_o(cur_state)
  );

  lese_update #(
    .SEGMENTS(SEGMENTS),
    .SW      (SW)
  ) u_update (
    .clk_i     (clk_i),
    .ld_i      (s1_adv),
    .op_i      (s1_op_q),
    .state_i   (cur_state),
    .rate_row_i(rate_row),
    .dest_row_i(dest_row),
    .cfg_i     (cfg_q),
    .state_o   (next_state)
  );

  // Report the voice; a voice beyond the count reads as idle at zero
  result_t res;
  result_t out_word;

  always_comb begin
    res.voice = s2_voice_q;
    if (s2_in_range_q) begin
      res.level = next_state.cur;
      res.phase = 2'(next_state.phase);
    end else begin
      res.level = '0;
      res.phase = 2'(PhIdle);
    end
  end

  lese_out_fifo u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s2_valid_q),
    .push_data_i(res),
    .pop_valid_o(out_valid_o),
    .pop_ready_i(out_ready_i),
    .pop_data_o (out_word),
    .fill_o     (fill)
  );

  assign voice_out_o = out_word.voice;
  assign level_o     = out_word.level;
  assign phase_out_o = out_word.phase;

endmodule
